/* sv/complex_arith_unit_defines.svh */
// Assertion macros for the complex arithmetic unit.
// Each macro checks one implication on the rising clock edge, disabled in reset.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/cau_pkg.sv */
package cau_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int EXT_W      = DATA_W + 1;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_LAT    = DIV_STEPS + 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;
    localparam int OP_W       = 4;
    localparam int ST_W       = 2;

    localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
    localparam logic [OP_W-1:0] OP_CONJ = 4'd4;
    localparam logic [OP_W-1:0] OP_NEG  = 4'd5;
    localparam logic [OP_W-1:0] OP_ABS2 = 4'd6;
    localparam logic [OP_W-1:0] OP_INV  = 4'd7;
    localparam logic [OP_W-1:0] OP_EQ   = 4'd8;
    localparam logic [OP_W-1:0] OP_NONE = 4'd15;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_SAT = 2'd1;
    localparam logic [ST_W-1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic [ST_W-1:0]          status;
    } t_out;

    // Classified item: decoded kind, operands, and the pair to be squared.
    typedef struct packed {
        logic [OP_W-1:0]          kind;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
        logic signed [DATA_W-1:0] sq_x;
        logic signed [DATA_W-1:0] sq_y;
    } t_work;

    // Side information that travels alongside the divider pipeline.
    typedef struct packed {
        logic              vld;
        logic [OP_W-1:0]   kind;
        logic              zdiv;
        logic              sat;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
    } t_tag;

    // Clamp a signed sum one bit wider than DATA_W; returns {saturated, value}.
    function automatic logic [DATA_W:0] sat_s(input logic signed [DATA_W:0] v);
        logic [DATA_W:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = {1'b1, v[DATA_W], {(DATA_W-1){~v[DATA_W]}}};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

    // Sign and magnitude to two's complement with clamping; returns {saturated, value}.
    function automatic logic [DATA_W:0] q_out(input logic neg, input logic [DATA_W:0] mag);
        logic [DATA_W:0]   r;
        logic [DATA_W-1:0] t;
        t = ~mag[DATA_W-1:0] + 1'b1;
        if (!neg) begin
            if (mag > {2'b00, {(DATA_W-1){1'b1}}}) begin
                r = {2'b10, {(DATA_W-1){1'b1}}};
            end else begin
                r = {1'b0, mag[DATA_W-1:0]};
            end
        end else begin
            if (mag > {2'b01, {(DATA_W-1){1'b0}}}) begin
                r = {2'b11, {(DATA_W-1){1'b0}}};
            end else begin
                r = {1'b0, t};
            end
        end
        return r;
    endfunction

endpackage

/* sv/cau_front.sv */
module cau_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cau_pkg::t_in   i_data,
    output logic           o_stall,
    input  logic           i_full,
    output logic           o_push,
    output cau_pkg::t_work o_work
);
    import cau_pkg::*;

    logic  r_f_valid;
    t_work r_f;
    t_work n_f;

    assign o_stall = r_f_valid && i_full;
    assign o_push  = r_f_valid && !i_full;
    assign o_work  = r_f;

    always_comb begin
        n_f      = '0;
        n_f.a_re = i_data.a_re;
        n_f.a_im = i_data.a_im;
        n_f.b_re = i_data.b_re;
        n_f.b_im = i_data.b_im;
        unique case (i_data.op) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CONJ, OP_NEG, OP_ABS2, OP_INV, OP_EQ: begin
                n_f.kind = i_data.op;
            end
            default: begin
                n_f.kind = OP_NONE;
            end
        endcase
        unique case (i_data.op) inside
            OP_DIV: begin
                n_f.sq_x = i_data.b_re;
                n_f.sq_y = i_data.b_im;
            end
            OP_ABS2, OP_INV: begin
                n_f.sq_x = i_data.a_re;
                n_f.sq_y = i_data.a_im;
            end
            default: begin
                n_f.sq_x = '0;
                n_f.sq_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (!o_stall) begin
            r_f_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_f <= n_f;
        end
    end

endmodule

/* sv/cau_fifo.sv */
module cau_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cau_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output cau_pkg::t_work o_data
);
    import cau_pkg::*;

    t_work              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* sv/cau_div.sv */
module cau_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [cau_pkg::SUM_W-1:0] i_num,
    input  logic [cau_pkg::PROD_W-1:0]       i_den,
    output logic                             o_neg,
    output logic [cau_pkg::DATA_W:0]         o_mag
);
    import cau_pkg::*;

    logic              r_a_neg;
    logic [PROD_W-1:0] r_a_mag;
    logic [PROD_W-1:0] r_a_den;
    logic [PROD_W-1:0] w_rem0;

    logic              r_neg [DIV_STEPS+1];
    logic              r_big [DIV_STEPS+1];
    logic [PROD_W-1:0] r_rem [DIV_STEPS+1];
    logic [PROD_W-1:0] r_den [DIV_STEPS+1];
    logic [DATA_W-1:0] r_low [DIV_STEPS+1];
    logic [DATA_W-1:0] r_q   [DIV_STEPS+1];

    // Take the magnitude of the exact numerator.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_neg <= i_num[SUM_W-1];
            r_a_mag <= PROD_W'(i_num[SUM_W-1] ? -i_num : i_num);
            r_a_den <= i_den;
        end
    end

    // Upper part of the scaled numerator; at or above the divisor the quotient overflows.
    assign w_rem0 = r_a_mag >> (DATA_W - FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= r_a_neg;
            r_big[0] <= (w_rem0 >= r_a_den);
            r_rem[0] <= w_rem0;
            r_den[0] <= r_a_den;
            r_low[0] <= DATA_W'(r_a_mag << FRAC_BITS);
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [PROD_W:0] w_t;
        logic            w_ge;

        assign w_t  = {r_rem[k-1], r_low[k-1][DATA_W-1]};
        assign w_ge = (w_t >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k] <= r_neg[k-1];
                r_big[k] <= r_big[k-1];
                r_den[k] <= r_den[k-1];
                r_rem[k] <= w_ge ? PROD_W'(w_t - {1'b0, r_den[k-1]}) : PROD_W'(w_t);
                r_low[k] <= r_low[k-1] << 1;
                r_q[k]   <= {r_q[k-1][DATA_W-2:0], w_ge};
            end
        end
    end

    assign o_neg = r_neg[DIV_STEPS];
    assign o_mag = r_big[DIV_STEPS] ? {1'b1, {DATA_W{1'b0}}} : {1'b0, r_q[DIV_STEPS]};

endmodule

/* sv/cau_back.sv */
module cau_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  cau_pkg::t_work i_work,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output cau_pkg::t_out  o_data
);
    import cau_pkg::*;

    localparam logic [PROD_W-1:0] DEN_SCALE = PROD_W'(1) << (2 * FRAC_BITS);
    localparam logic [DATA_W-1:0] ONE       = DATA_W'(1) << FRAC_BITS;

    logic w_en;

    logic                     r_s1_vld;
    t_work                    r_s1;
    logic signed [PROD_W-1:0] r_p_rr;
    logic signed [PROD_W-1:0] r_p_ii;
    logic signed [PROD_W-1:0] r_p_ir;
    logic signed [PROD_W-1:0] r_p_ri;
    logic signed [PROD_W-1:0] r_sx2;
    logic signed [PROD_W-1:0] r_sy2;

    logic signed [SUM_W-1:0] w_nre;
    logic signed [SUM_W-1:0] w_nim;
    logic [PROD_W-1:0]       w_den;
    logic signed [EXT_W-1:0] w_t_re;
    logic signed [EXT_W-1:0] w_t_im;
    logic [DATA_W:0]         w_s_re;
    logic [DATA_W:0]         w_s_im;
    t_tag                    w_tag;

    t_tag                    r_s2_tag;
    logic signed [SUM_W-1:0] r_s2_nre;
    logic signed [SUM_W-1:0] r_s2_nim;
    logic [PROD_W-1:0]       r_s2_den;

    t_tag r_tag [DIV_LAT];

    logic            w_re_neg;
    logic            w_im_neg;
    logic [DATA_W:0] w_re_mag;
    logic [DATA_W:0] w_im_mag;
    logic [DATA_W:0] w_q_re;
    logic [DATA_W:0] w_q_im;
    t_tag            w_end;
    t_out            w_out;

    logic r_o_valid;
    t_out r_out;

    // The whole pipeline advances unless a finished result is held back.
    assign w_en    = !(r_o_valid && i_stall);
    assign o_pop   = w_en && !i_empty;
    assign o_valid = r_o_valid;
    assign o_data  = r_out;

    // Multiply stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1   <= i_work;
            r_p_rr <= PROD_W'(i_work.a_re) * PROD_W'(i_work.b_re);
            r_p_ii <= PROD_W'(i_work.a_im) * PROD_W'(i_work.b_im);
            r_p_ir <= PROD_W'(i_work.a_im) * PROD_W'(i_work.b_re);
            r_p_ri <= PROD_W'(i_work.a_re) * PROD_W'(i_work.b_im);
            r_sx2  <= PROD_W'(i_work.sq_x) * PROD_W'(i_work.sq_x);
            r_sy2  <= PROD_W'(i_work.sq_y) * PROD_W'(i_work.sq_y);
        end
    end

    // Combine stage: exact numerators and divisor, plus the short operations.
    always_comb begin
        w_nre = '0;
        w_nim = '0;
        w_den = DEN_SCALE;
        case (r_s1.kind) inside
            OP_MUL: begin
                w_nre = SUM_W'(r_p_rr) - SUM_W'(r_p_ii);
                w_nim = SUM_W'(r_p_ir) + SUM_W'(r_p_ri);
            end
            OP_DIV: begin
                w_nre = SUM_W'(r_p_rr) + SUM_W'(r_p_ii);
                w_nim = SUM_W'(r_p_ir) - SUM_W'(r_p_ri);
                w_den = PROD_W'(r_sx2) + PROD_W'(r_sy2);
            end
            OP_INV: begin
                w_nre = SUM_W'(r_s1.a_re) <<< FRAC_BITS;
                w_nim = -(SUM_W'(r_s1.a_im) <<< FRAC_BITS);
                w_den = PROD_W'(r_sx2) + PROD_W'(r_sy2);
            end
            OP_ABS2: begin
                w_nre = SUM_W'(r_sx2) + SUM_W'(r_sy2);
            end
            default: begin
                w_nre = '0;
            end
        endcase
    end

    always_comb begin
        w_t_re = '0;
        w_t_im = '0;
        case (r_s1.kind) inside
            OP_ADD: begin
                w_t_re = EXT_W'(r_s1.a_re) + EXT_W'(r_s1.b_re);
                w_t_im = EXT_W'(r_s1.a_im) + EXT_W'(r_s1.b_im);
            end
            OP_SUB: begin
                w_t_re = EXT_W'(r_s1.a_re) - EXT_W'(r_s1.b_re);
                w_t_im = EXT_W'(r_s1.a_im) - EXT_W'(r_s1.b_im);
            end
            OP_CONJ: begin
                w_t_re = EXT_W'(r_s1.a_re);
                w_t_im = -EXT_W'(r_s1.a_im);
            end
            OP_NEG: begin
                w_t_re = -EXT_W'(r_s1.a_re);
                w_t_im = -EXT_W'(r_s1.a_im);
            end
            OP_EQ: begin
                if ((r_s1.a_re == r_s1.b_re) && (r_s1.a_im == r_s1.b_im)) begin
                    w_t_re = EXT_W'(ONE);
                end
            end
            default: begin
                w_t_re = '0;
            end
        endcase
    end

    assign w_s_re = sat_s(w_t_re);
    assign w_s_im = sat_s(w_t_im);

    always_comb begin
        w_tag      = '0;
        w_tag.vld  = r_s1_vld;
        w_tag.kind = r_s1.kind;
        w_tag.zdiv = ((r_s1.kind == OP_DIV) || (r_s1.kind == OP_INV))
                     && (r_sx2 == '0) && (r_sy2 == '0);
        w_tag.sat  = w_s_re[DATA_W] || w_s_im[DATA_W];
        w_tag.re   = w_s_re[DATA_W-1:0];
        w_tag.im   = w_s_im[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tag.vld <= 1'b0;
        end else if (w_en) begin
            r_s2_tag <= w_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_nre <= w_nre;
            r_s2_nim <= w_nim;
            r_s2_den <= w_den;
        end
    end

    cau_div u_div_re (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s2_nre),
        .i_den (r_s2_den),
        .o_neg (w_re_neg),
        .o_mag (w_re_mag)
    );

    cau_div u_div_im (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s2_nim),
        .i_den (r_s2_den),
        .o_neg (w_im_neg),
        .o_mag (w_im_mag)
    );

    // Side information line, aligned with the divider depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_tag[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_tag[0] <= r_s2_tag;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign w_end  = r_tag[DIV_LAT-1];
    assign w_q_re = q_out(w_re_neg, w_re_mag);
    assign w_q_im = q_out(w_im_neg, w_im_mag);

    always_comb begin
        w_out = '0;
        case (w_end.kind) inside
            OP_MUL, OP_DIV, OP_INV, OP_ABS2: begin
                if (w_end.zdiv) begin
                    w_out.status = ST_DZ;
                end else begin
                    w_out.res_re = $signed(w_q_re[DATA_W-1:0]);
                    w_out.res_im = $signed(w_q_im[DATA_W-1:0]);
                    w_out.status = (w_q_re[DATA_W] || w_q_im[DATA_W]) ? ST_SAT : ST_OK;
                end
            end
            default: begin
                w_out.res_re = $signed(w_end.re);
                w_out.res_im = $signed(w_end.im);
                w_out.status = w_end.sat ? ST_SAT : ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_end.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_out;
        end
    end

endmodule

/* sv/complex_arith_unit.sv */
// Complex arithmetic unit on signed fixed point operands.
// Throughput: one transaction per cycle unless i_stall holds a finished result back.
// The 32-step pipelined divider sets the depth.
// Reset: synchronous, active low; clears valid flags and FIFO pointers and count only.
`include "complex_arith_unit_defines.svh"

module complex_arith_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cau_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output cau_pkg::t_out o_data,
    input  logic          i_stall
);
    import cau_pkg::*;

    // Front: register the incoming transaction, decode the op code and pick the
    // operand pair to square (divisor for division, operand itself for abs2 and
    // inverse). Hold the transaction while the FIFO is full.
    logic  w_push;
    logic  w_full;
    t_work w_work_in;

    // Back side of the FIFO.
    logic  w_pop;
    logic  w_empty;
    t_work w_work_out;

    // Output status decode and clamp detection for the checks below.
    logic w_out_dz;
    logic w_out_sat;
    logic w_out_zero;
    logic w_re_clamp;
    logic w_im_clamp;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_work  (w_work_in)
    );

    // Short queue decoupling the classifier from the arithmetic pipeline, so
    // either side can stall without a combinational path through the other.
    cau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_work_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_work_out)
    );

    // Back: multiply, combine into exact numerators and divisor, run both parts
    // through the restoring divider (products scale back by dividing by a power
    // of two), then clamp and register the result. Advance only when the output
    // register is free or drains this cycle.
    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_work  (w_work_out),
        .o_pop   (w_pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    assign w_out_dz   = o_valid && (o_data.status == ST_DZ);
    assign w_out_sat  = o_valid && (o_data.status == ST_SAT);
    assign w_out_zero = (o_data.res_re == '0) && (o_data.res_im == '0);
    assign w_re_clamp = (o_data.res_re == 32'sh7fffffff) || (o_data.res_re == 32'sh80000000);
    assign w_im_clamp = (o_data.res_im == 32'sh7fffffff) || (o_data.res_im == 32'sh80000000);

    // A divide-by-zero result carries zero parts.
    `CAU_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, w_out_dz, w_out_zero)
    // A saturated result has at least one part at a clamp value.
    `CAU_ASSERT_IMP(a_sat_clamp, i_clk, i_rst_n, w_out_sat, w_re_clamp || w_im_clamp)
    // A full FIFO with nothing popped stays full.
    `CAU_ASSERT_NXT(a_fifo_hold, i_clk, i_rst_n, w_full && !w_pop, w_full)

endmodule
